// ===== hw/rtl/scq_pkg.sv =====
package scq_pkg;

  localparam int VAL_W  = 32;
  localparam int COL_W  = 24;
  localparam int SLOT_W = 2;
  localparam int Q_W    = 17;
  localparam int ROWS_W = 11;
  localparam int NQ_W   = 3;
  localparam int CIDX_W = 3;

  localparam int DEF_MAX_ROWS      = 1024;
  localparam int DEF_MAX_QUANTILES = 4;

  localparam logic [Q_W-1:0] ONE_Q16 = 17'd65536;
  localparam logic [Q_W-1:0] HALF_Q16 = 17'd32768;

  // configuration register indexes
  localparam logic [CIDX_W-1:0] CFG_ROWS  = 3'd0;
  localparam logic [CIDX_W-1:0] CFG_NQ    = 3'd1;
  localparam logic [CIDX_W-1:0] CFG_Q0    = 3'd2;
  localparam logic [CIDX_W-1:0] CFG_Q3    = 3'd5;
  localparam logic [CIDX_W-1:0] CFG_ALPHA = 3'd6;
  localparam logic [CIDX_W-1:0] CFG_BETA  = 3'd7;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic             has_value;
    logic             end_of_column;
  } item_t;

  typedef struct packed {
    logic [ROWS_W-1:0] rows;
    logic [NQ_W-1:0]   nq;
    logic [Q_W-1:0]    alpha;
    logic [Q_W-1:0]    beta;
  } cfg_t;

  function automatic logic [Q_W-1:0] sat_one(input logic [Q_W-1:0] v);
    return (v > ONE_Q16) ? ONE_Q16 : v;
  endfunction

endpackage

// ===== hw/rtl/sparse_column_quantile_core.sv =====
// flow: a stored value is registered in the two-entry queue before it reaches the back end;
// a column's first value is written straight into the sorted store, a later one steps
// through read and compare states, moving larger values up, until its place is found
// the back end takes a new value only when idle; input stalls once the queue is full.
// a column end runs states QA through QF for each quantile result, QF waiting on output stalls
// reset: rst_n synchronous active low, clears counts, column counter, queue and output valid
module sparse_column_quantile_core #(
  parameter int MAX_ROWS      = scq_pkg::DEF_MAX_ROWS,
  parameter int MAX_QUANTILES = scq_pkg::DEF_MAX_QUANTILES
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [31:0]                   in_tdata,   // value
  input  logic                          in_tuser,   // has_value
  input  logic                          in_tlast,   // end_of_column
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [55:0]                   out_tdata,  // column_index, quantile_value
  output logic [2:0]                    out_tuser,  // quantile_slot, overflowed
  output logic                          out_tlast,  // last_of_column
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [scq_pkg::CIDX_W-1:0]    cfg_index,
  input  logic [scq_pkg::Q_W-1:0]       cfg_data
);
  import scq_pkg::*;

  localparam int QIW = (MAX_QUANTILES > 1) ? $clog2(MAX_QUANTILES) : 1;

  cfg_t              cfg_r;
  logic [Q_W-1:0]    quant_r [MAX_QUANTILES];
  logic [CIDX_W-1:0] qsel;
  item_t             in_item, q_item;
  logic              q_valid, q_ready;
  logic [COL_W-1:0]  o_col;
  logic [SLOT_W-1:0] o_slot;
  logic [VAL_W-1:0]  o_value;
  logic              o_ovf;

  assign cfg_ready = 1'b1;
  assign qsel      = cfg_index - CFG_Q0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rows  <= 11'd1024;
      cfg_r.nq    <= 3'd1;
      cfg_r.alpha <= ONE_Q16;
      cfg_r.beta  <= ONE_Q16;
      for (int i = 0; i < MAX_QUANTILES; i++) quant_r[i] <= HALF_Q16;
    end else if (cfg_valid) begin
      unique case (cfg_index) inside
        CFG_ROWS:  cfg_r.rows  <= cfg_data[ROWS_W-1:0];
        CFG_NQ:    cfg_r.nq    <= cfg_data[NQ_W-1:0];
        [CFG_Q0:CFG_Q3]: begin
          if (32'(qsel) < MAX_QUANTILES) quant_r[qsel[QIW-1:0]] <= cfg_data;
        end
        CFG_ALPHA: cfg_r.alpha <= cfg_data;
        CFG_BETA:  cfg_r.beta  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_item = {in_tdata, in_tuser, in_tlast};

  scq_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_tvalid),
    .in_ready(in_tready),
    .in_item (in_item),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_item  (q_item)
  );

  scq_back #(
    .MAX_ROWS     (MAX_ROWS),
    .MAX_QUANTILES(MAX_QUANTILES)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_item   (q_item),
    .cfg      (cfg_r),
    .quant    (quant_r),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_col  (o_col),
    .out_slot (o_slot),
    .out_value(o_value),
    .out_ovf  (o_ovf),
    .out_last (out_tlast)
  );

  assign out_tdata = {o_value, o_col};
  assign out_tuser = {o_ovf, o_slot};

endmodule

// ===== hw/rtl/scq_front.sv =====
module scq_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  scq_pkg::item_t in_item,
  output logic          q_valid,
  input  logic          q_ready,
  output scq_pkg::item_t q_item
);
  import scq_pkg::*;

  item_t       fifo_r [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        push, pop;

  assign in_ready = (cnt_r != 2'd2);
  // an item with neither a value nor a column end has no effect, so it is not queued
  assign push     = in_valid && in_ready && (in_item.has_value || in_item.end_of_column);
  assign q_valid  = (cnt_r != 2'd0);
  assign pop      = q_valid && q_ready;
  assign q_item   = fifo_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= in_item;
    end
  end

endmodule

// ===== hw/rtl/scq_back.sv =====
module scq_back #(
  parameter int MAX_ROWS      = scq_pkg::DEF_MAX_ROWS,
  parameter int MAX_QUANTILES = scq_pkg::DEF_MAX_QUANTILES
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_valid,
  output logic                         q_ready,
  input  scq_pkg::item_t               q_item,
  input  scq_pkg::cfg_t                cfg,
  input  logic [scq_pkg::Q_W-1:0]      quant [MAX_QUANTILES],
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [scq_pkg::COL_W-1:0]    out_col,
  output logic [scq_pkg::SLOT_W-1:0]   out_slot,
  output logic [scq_pkg::VAL_W-1:0]    out_value,
  output logic                         out_ovf,
  output logic                         out_last
);
  import scq_pkg::*;

  localparam int AW  = $clog2(MAX_ROWS);
  localparam int CW  = $clog2(MAX_ROWS + 1);
  localparam int QIW = (MAX_QUANTILES > 1) ? $clog2(MAX_QUANTILES) : 1;
  localparam int ALW = CW + 36;
  localparam int PW  = VAL_W + 18;

  typedef enum logic [10:0] {
    S_IDLE = 11'b000_0000_0001,
    S_RD   = 11'b000_0000_0010,
    S_CMP  = 11'b000_0000_0100,
    S_PUT  = 11'b000_0000_1000,
    S_QA   = 11'b000_0001_0000,
    S_QB   = 11'b000_0010_0000,
    S_QG   = 11'b000_0100_0000,
    S_QC   = 11'b000_1000_0000,
    S_QD   = 11'b001_0000_0000,
    S_QE   = 11'b010_0000_0000,
    S_QF   = 11'b100_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  logic [VAL_W-1:0] mem [MAX_ROWS];
  logic [VAL_W-1:0] rd_r;
  logic             we;
  logic [AW-1:0]    wa, ra;
  logic [VAL_W-1:0] wd;

  logic [CW-1:0]    cnt_r, neg_r;
  logic             ovf_r;
  logic [COL_W-1:0] col_r;
  logic [VAL_W-1:0] key_r;
  logic             eoc_r;
  logic [AW-1:0]    j_r;
  logic [SLOT_W-1:0] k_r;

  logic [Q_W+CW-1:0]   p1_r;
  logic signed [36:0]  p2_r;
  logic signed [ALW-1:0] aleph_r;
  logic [CW-1:0]       idx_r;
  logic [Q_W-1:0]      g_r;
  logic                lo_zero_r, hi_zero_r;
  logic signed [VAL_W-1:0] lo_r, hi_r;
  logic signed [PW-1:0] prod_r;

  logic                out_valid_r;
  logic [COL_W-1:0]    out_col_r;
  logic [SLOT_W-1:0]   out_slot_r;
  logic [VAL_W-1:0]    out_value_r;
  logic                out_ovf_r;
  logic                out_last_r;

  logic [CW-1:0]    rows_eff;
  logic [NQ_W-1:0]  nq_eff;
  logic [Q_W-1:0]   a_s, b_s, q_s;
  logic signed [18:0] d_s;
  logic [CW-1:0]    zeros_c;
  logic signed [ALW-1:0] aleph_c, cl_c, lo_lim, hi_lim;
  logic signed [ALW-1:0] g32_c;
  logic [32:0]      g32c;
  logic [CW:0]      lo_map, hi_map;
  logic signed [PW:0] acc_c;
  logic             out_free, last_q;

  // rank to store position, implied zeros sit between negatives and positives
  function automatic logic [CW:0] map_rank(input logic [CW-1:0] rank,
                                           input logic [CW-1:0] neg,
                                           input logic [CW-1:0] zeros,
                                           input logic [CW-1:0] n);
    logic [CW:0] r, pos;
    logic        zero;
    r    = {1'b0, rank};
    zero = 1'b0;
    pos  = r;
    if (r < {1'b0, neg}) begin
      pos = r;
    end else if (r < ({1'b0, neg} + {1'b0, zeros})) begin
      zero = 1'b1;
    end else begin
      pos = r - {1'b0, zeros};
    end
    if (pos >= {1'b0, n}) zero = 1'b1;
    return {zero, pos[CW-1:0]};
  endfunction

  always_comb begin
    if (cfg.rows < 11'd2) begin
      rows_eff = CW'(2);
    end else if (32'(cfg.rows) > MAX_ROWS) begin
      rows_eff = CW'(MAX_ROWS);
    end else begin
      rows_eff = CW'(cfg.rows);
    end
    if (cfg.nq == 3'd0) begin
      nq_eff = 3'd1;
    end else if (32'(cfg.nq) > MAX_QUANTILES) begin
      nq_eff = NQ_W'(MAX_QUANTILES);
    end else begin
      nq_eff = cfg.nq;
    end
  end

  assign a_s     = sat_one(cfg.alpha);
  assign b_s     = sat_one(cfg.beta);
  assign q_s     = sat_one(quant[k_r[QIW-1:0]]);
  assign d_s     = 19'sd65536 - $signed({2'b00, a_s}) - $signed({2'b00, b_s});
  assign zeros_c = (cnt_r < rows_eff) ? (rows_eff - cnt_r) : '0;
  assign last_q  = ({1'b0, k_r} + 3'd1 == nq_eff);
  assign out_free = !out_valid_r || out_ready;

  // aleph and its clamp, in units of 2^-32
  always_comb begin
    aleph_c = $signed({3'b000, p1_r, 16'h0000})
            + $signed({{(ALW-33){1'b0}}, a_s, 16'h0000})
            + $signed({{(ALW-37){p2_r[36]}}, p2_r});
    lo_lim  = $signed({{(ALW-33){1'b0}}, 1'b1, 32'h0});
    hi_lim  = $signed({4'b0000, rows_eff - CW'(1), 32'h0});
    if (aleph_c < lo_lim) begin
      cl_c = lo_lim;
    end else if (aleph_c > hi_lim) begin
      cl_c = hi_lim;
    end else begin
      cl_c = aleph_c;
    end
    g32_c = aleph_r - $signed({4'b0000, idx_r, 32'h0});
    if (g32_c < 0) begin
      g32c = '0;
    end else if (g32_c > lo_lim) begin
      g32c = {1'b1, 32'h0};
    end else begin
      g32c = g32_c[32:0];
    end
  end

  assign lo_map = map_rank(idx_r - CW'(1), neg_r, zeros_c, cnt_r);
  assign hi_map = map_rank(idx_r, neg_r, zeros_c, cnt_r);
  assign acc_c  = $signed({prod_r[PW-1], prod_r})
                + $signed(PW'(hi_r * $signed({1'b0, g_r})))
                + $signed((PW+1)'(HALF_Q16));

  assign q_ready = (state_r == S_IDLE);

  always_comb begin
    we = 1'b0;
    wa = j_r;
    wd = key_r;
    ra = j_r - AW'(1);
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          if (q_item.has_value && (cnt_r < rows_eff)) begin
            state_nxt = (cnt_r == '0) ? S_PUT : S_RD;
          end else if (q_item.end_of_column) begin
            state_nxt = S_QA;
          end
        end
      end
      S_RD: state_nxt = S_CMP;
      S_CMP: begin
        we = 1'b1;
        if ($signed(rd_r) > $signed(key_r)) begin
          wd = rd_r;
          state_nxt = (j_r == AW'(1)) ? S_PUT : S_RD;
        end else begin
          state_nxt = eoc_r ? S_QA : S_IDLE;
        end
      end
      S_PUT: begin
        we = 1'b1;
        state_nxt = eoc_r ? S_QA : S_IDLE;
      end
      S_QA: state_nxt = S_QB;
      S_QB: state_nxt = S_QG;
      S_QG: state_nxt = S_QC;
      S_QC: begin
        ra = lo_map[AW-1:0];
        state_nxt = S_QD;
      end
      S_QD: begin
        ra = hi_map[AW-1:0];
        state_nxt = S_QE;
      end
      S_QE: state_nxt = S_QF;
      S_QF: begin
        if (out_free) state_nxt = last_q ? S_IDLE : S_QA;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_r <= mem[ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      neg_r       <= '0;
      ovf_r       <= 1'b0;
      col_r       <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if ((state_r == S_QF) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          k_r <= '0;
          if (q_valid && q_item.has_value) begin
            if (cnt_r < rows_eff) begin
              cnt_r <= cnt_r + CW'(1);
              if (q_item.value[VAL_W-1]) neg_r <= neg_r + CW'(1);
            end else begin
              ovf_r <= 1'b1;
            end
          end
        end
        S_QF: begin
          if (out_free) begin
            k_r <= k_r + SLOT_W'(1);
            if (last_q) begin
              cnt_r <= '0;
              neg_r <= '0;
              ovf_r <= 1'b0;
              col_r <= col_r + COL_W'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        key_r <= q_item.value;
        eoc_r <= q_item.end_of_column;
        j_r   <= cnt_r[AW-1:0];
      end
      S_CMP: begin
        if ($signed(rd_r) > $signed(key_r)) j_r <= j_r - AW'(1);
      end
      S_QA: begin
        p1_r <= q_s * rows_eff;
        p2_r <= $signed({1'b0, q_s}) * d_s;
      end
      S_QB: begin
        aleph_r <= aleph_c;
        idx_r   <= cl_c[CW+31:32];
      end
      S_QG: g_r <= g32c[32:16] + {16'h0000, g32c[15]};
      S_QC: lo_zero_r <= lo_map[CW];
      S_QD: begin
        lo_r      <= lo_zero_r ? '0 : $signed(rd_r);
        hi_zero_r <= hi_map[CW];
      end
      S_QE: begin
        hi_r   <= hi_zero_r ? '0 : $signed(rd_r);
        prod_r <= lo_r * $signed({1'b0, ONE_Q16 - g_r});
      end
      S_QF: begin
        if (out_free) begin
          out_col_r   <= col_r;
          out_slot_r  <= k_r;
          out_value_r <= acc_c[VAL_W+15:16];
          out_ovf_r   <= ovf_r;
          out_last_r  <= last_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_col   = out_col_r;
  assign out_slot  = out_slot_r;
  assign out_value = out_value_r;
  assign out_ovf   = out_ovf_r;
  assign out_last  = out_last_r;

endmodule

// ===== hw/rtl/scq_checker.sv =====
module scq_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [55:0] out_tdata,
  input logic [2:0]  out_tuser,
  input logic        out_tlast
);
  logic [1:0]  exp_slot_r;
  logic [23:0] exp_col_r;
  logic        xfer;

  assign xfer = out_tvalid && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_slot_r <= 2'd0;
      exp_col_r  <= 24'd0;
    end else if (xfer) begin
      exp_slot_r <= out_tlast ? 2'd0 : out_tuser[1:0] + 2'd1;
      if (out_tlast) exp_col_r <= out_tdata[23:0] + 24'd1;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser[1:0] == exp_slot_r)
    else $error("quantile slot out of order");

  a_col: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[23:0] == exp_col_r)
    else $error("column index out of sequence");

  a_last_slot: assert property (@(posedge clk) disable iff (!rst_n)
    xfer && !out_tlast |-> out_tuser[1:0] != 2'd3)
    else $error("more than four results in a column");

endmodule

bind sparse_column_quantile_core scq_checker u_scq_checker (.*);
